@@ rtl/core/tone_melody_sequencer_core_macros.svh @@
// Assertion macros used by the tone melody sequencer core.
`ifndef TONE_MELODY_SEQUENCER_CORE_MACROS_SVH
`define TONE_MELODY_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tms_pkg.sv @@
// Types, constants and note table of the tone melody sequencer.
package tms_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CMP_BITS   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	typedef logic [TIMER_BITS-1:0] timer_t;
	localparam timer_t TIMER_MAX = '1;

	typedef enum logic [2:0] {
		CMD_TICK     = 3'd0,
		CMD_DETECT   = 3'd1,
		CMD_SUCCESS  = 3'd2,
		CMD_ERROR    = 3'd3,
		CMD_CONFIRM  = 3'd4,
		CMD_SCHEDULE = 3'd5,
		CMD_STOP     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_START = 2'd1,
		ACT_STOP  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		REG_ENABLED       = 3'd0,
		REG_PITCH_LOW     = 3'd1,
		REG_PITCH_MID     = 3'd2,
		REG_PITCH_HIGH    = 3'd3,
		REG_PITCH_CONFIRM = 3'd4,
		REG_LEN_SHORT     = 3'd5,
		REG_LEN_MID       = 3'd6,
		REG_LEN_LONG      = 3'd7
	} reg_index_t;

	localparam logic SEL_SUCCESS = 1'b0;
	localparam logic SEL_ERROR   = 1'b1;

	localparam logic [5:0] PAUSE_NONE    = 6'd0;
	localparam logic [5:0] PAUSE_SUCCESS = 6'd30;
	localparam logic [5:0] PAUSE_ERROR   = 6'd50;

	typedef struct packed {
		logic        enabled;
		logic [15:0] pitch_low;
		logic [15:0] pitch_mid;
		logic [15:0] pitch_high;
		logic [15:0] pitch_confirm;
		logic [15:0] len_short;
		logic [15:0] len_mid;
		logic [15:0] len_long;
	} cfg_t;

	typedef struct packed {
		logic        sounding;
		logic        melody_running;
		logic        melody_select;
		logic [1:0]  note_index;
		logic        in_gap;
		timer_t      note_timer;
		logic        sched_pending;
		timer_t      sched_timer;
		logic [15:0] sched_delay;
	} state_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] delay_ms;
		logic        driver_busy;
	} item_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] tone_freq;
		logic [15:0] tone_ms;
		logic        playing;
		logic        melody_on;
		logic        pending;
	} result_t;

	typedef struct packed {
		logic [15:0] freq;
		logic [15:0] dur;
		logic [5:0]  pause;
	} note_t;

	function automatic logic [1:0] melody_len(logic sel);
		return (sel == SEL_ERROR) ? 2'd2 : 2'd3;
	endfunction

	// Note table of both melodies; the index must be below the melody length.
	function automatic note_t note_of(logic sel, logic [1:0] idx, cfg_t cfg);
		note_t n;
		if (sel == SEL_SUCCESS) begin
			case (idx)
				2'd0: n = '{freq: cfg.pitch_low, dur: cfg.len_short, pause: PAUSE_SUCCESS};
				2'd1: n = '{freq: cfg.pitch_mid, dur: cfg.len_short, pause: PAUSE_SUCCESS};
				default: n = '{freq: cfg.pitch_high, dur: cfg.len_mid, pause: PAUSE_NONE};
			endcase
		end else begin
			case (idx)
				2'd0: n = '{freq: cfg.pitch_mid, dur: cfg.len_mid, pause: PAUSE_ERROR};
				default: n = '{freq: cfg.pitch_low, dur: cfg.len_long, pause: PAUSE_NONE};
			endcase
		end
		return n;
	endfunction

	function automatic timer_t sat_inc(timer_t t);
		return (t == TIMER_MAX) ? t : t + timer_t'(1);
	endfunction

	function automatic logic at_least(timer_t t, logic [15:0] lim);
		return CMP_BITS'(t) >= CMP_BITS'(lim);
	endfunction

endpackage

@@ rtl/core/tms_cfg_regs.sv @@
// Configuration register file of the tone melody sequencer.
module tms_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output tms_pkg::cfg_t     cfg
);

	tms_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled       <= 1'b0;
			cfg_q.pitch_low     <= 16'd1000;
			cfg_q.pitch_mid     <= 16'd2000;
			cfg_q.pitch_high    <= 16'd3000;
			cfg_q.pitch_confirm <= 16'd2500;
			cfg_q.len_short     <= 16'd50;
			cfg_q.len_mid       <= 16'd100;
			cfg_q.len_long      <= 16'd200;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tms_pkg::REG_ENABLED:       cfg_q.enabled       <= cfg_data[0];
				tms_pkg::REG_PITCH_LOW:     cfg_q.pitch_low     <= cfg_data;
				tms_pkg::REG_PITCH_MID:     cfg_q.pitch_mid     <= cfg_data;
				tms_pkg::REG_PITCH_HIGH:    cfg_q.pitch_high    <= cfg_data;
				tms_pkg::REG_PITCH_CONFIRM: cfg_q.pitch_confirm <= cfg_data;
				tms_pkg::REG_LEN_SHORT:     cfg_q.len_short     <= cfg_data;
				tms_pkg::REG_LEN_MID:       cfg_q.len_mid       <= cfg_data;
				tms_pkg::REG_LEN_LONG:      cfg_q.len_long      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/tms_step.sv @@
// Next-state and driver action logic for one command of the sequencer.
module tms_step (
	input  tms_pkg::cfg_t    cfg,
	input  tms_pkg::state_t  st,
	input  tms_pkg::item_t   item,
	output tms_pkg::state_t  st_nxt,
	output tms_pkg::result_t res
);

	always_comb begin
		tms_pkg::note_t nt;
		tms_pkg::note_t nt_next;
		logic           mel_start;
		logic           mel_sel;
		logic           go_next;
		logic [1:0]     idx_next;

		st_nxt    = st;
		res       = '0;
		mel_start = 1'b0;
		mel_sel   = tms_pkg::SEL_SUCCESS;
		go_next   = 1'b0;
		nt        = tms_pkg::note_of(st.melody_select, st.note_index, cfg);
		idx_next  = st.note_index + 2'd1;
		nt_next   = tms_pkg::note_of(st.melody_select, idx_next, cfg);

		if (cfg.enabled) begin
			case (item.cmd)
				tms_pkg::CMD_TICK: begin
					st_nxt.note_timer = tms_pkg::sat_inc(st.note_timer);
					if (st.sched_pending) begin
						st_nxt.sched_timer = tms_pkg::sat_inc(st.sched_timer);
					end
					if (st.sched_pending &&
					    tms_pkg::at_least(st_nxt.sched_timer, st.sched_delay)) begin
						st_nxt.sched_pending = 1'b0;
						mel_start            = 1'b1;
					end else if (st.melody_running) begin
						if (st.note_index >= tms_pkg::melody_len(st.melody_select)) begin
							st_nxt.melody_running = 1'b0;
							st_nxt.sounding       = 1'b0;
						end else if (st.in_gap) begin
							go_next = tms_pkg::at_least(st_nxt.note_timer, {10'd0, nt.pause});
						end else if (tms_pkg::at_least(st_nxt.note_timer, nt.dur)) begin
							if (nt.pause != tms_pkg::PAUSE_NONE) begin
								res.action        = tms_pkg::ACT_STOP;
								st_nxt.in_gap     = 1'b1;
								st_nxt.note_timer = '0;
							end else begin
								go_next = 1'b1;
							end
						end
						if (go_next) begin
							st_nxt.note_index = idx_next;
							st_nxt.in_gap     = 1'b0;
							if (idx_next >= tms_pkg::melody_len(st.melody_select)) begin
								st_nxt.melody_running = 1'b0;
								st_nxt.sounding       = 1'b0;
							end else begin
								res.action        = tms_pkg::ACT_START;
								res.tone_freq     = nt_next.freq;
								res.tone_ms       = nt_next.dur;
								st_nxt.note_timer = '0;
							end
						end
					end
					// A lone tone follows the driver's busy flag.
					if (!mel_start && st_nxt.sounding && !st_nxt.melody_running) begin
						st_nxt.sounding = item.driver_busy;
					end
				end
				tms_pkg::CMD_DETECT: begin
					res.action        = tms_pkg::ACT_START;
					res.tone_freq     = cfg.pitch_mid;
					res.tone_ms       = cfg.len_short;
					st_nxt.sounding   = 1'b1;
					st_nxt.note_timer = '0;
				end
				tms_pkg::CMD_SUCCESS: begin
					mel_start = 1'b1;
				end
				tms_pkg::CMD_ERROR: begin
					mel_start = 1'b1;
					mel_sel   = tms_pkg::SEL_ERROR;
				end
				tms_pkg::CMD_CONFIRM: begin
					res.action        = tms_pkg::ACT_START;
					res.tone_freq     = cfg.pitch_confirm;
					res.tone_ms       = cfg.len_mid;
					st_nxt.sounding   = 1'b1;
					st_nxt.note_timer = '0;
				end
				tms_pkg::CMD_SCHEDULE: begin
					st_nxt.sched_pending = 1'b1;
					st_nxt.sched_timer   = '0;
					st_nxt.sched_delay   = item.delay_ms;
				end
				tms_pkg::CMD_STOP: begin
					res.action            = tms_pkg::ACT_STOP;
					st_nxt.sounding       = 1'b0;
					st_nxt.melody_running = 1'b0;
					st_nxt.sched_pending  = 1'b0;
				end
				default: ;
			endcase
		end

		if (mel_start) begin
			nt                    = tms_pkg::note_of(mel_sel, 2'd0, cfg);
			st_nxt.melody_select  = mel_sel;
			st_nxt.note_index     = 2'd0;
			st_nxt.melody_running = 1'b1;
			st_nxt.in_gap         = 1'b0;
			st_nxt.note_timer     = '0;
			st_nxt.sounding       = 1'b1;
			res.action            = tms_pkg::ACT_START;
			res.tone_freq         = nt.freq;
			res.tone_ms           = nt.dur;
		end

		res.playing   = st_nxt.sounding;
		res.melody_on = st_nxt.melody_running;
		res.pending   = st_nxt.sched_pending;
	end

endmodule

@@ rtl/core/tone_melody_sequencer_core.sv @@
// Tone melody sequencer top level: input register, step logic and result register.
// Path: a command is registered in the input stage, and its result then in the result
// register, which drives out_valid; the input stage stalls while a result waits untaken.
// Throughput: one command per cycle while results are taken; else one more can enter.
// Reset: arst_n clears the sequencer state and both stage valids and loads the
// configuration registers with their default values.
`include "tone_melody_sequencer_core_macros.svh"

module tone_melody_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] delay_ms,
	input  logic        driver_busy,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [15:0] tone_freq,
	output logic [15:0] tone_ms,
	output logic        playing,
	output logic        melody_on,
	output logic        pending,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tms_pkg::cfg_t    cfg;
	tms_pkg::item_t   item_s1;
	logic             valid_s1;
	tms_pkg::state_t  st_q;
	tms_pkg::state_t  st_nxt;
	tms_pkg::result_t res;
	tms_pkg::result_t res_q;
	logic             out_valid_q;
	logic             out_free;
	logic             fire_s1;

	tms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tms_step u_step (
		.cfg    (cfg),
		.st     (st_q),
		.item   (item_s1),
		.st_nxt (st_nxt),
		.res    (res)
	);

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd         <= cmd;
			item_s1.delay_ms    <= delay_ms;
			item_s1.driver_busy <= driver_busy;
		end
		if (fire_s1) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = res_q.action;
	assign tone_freq = res_q.tone_freq;
	assign tone_ms   = res_q.tone_ms;
	assign playing   = res_q.playing;
	assign melody_on = res_q.melody_on;
	assign pending   = res_q.pending;

	// A running melody always keeps the buzzer marked as sounding.
	`TMS_ASSERT_NOW(a_melody_sounds, st_q.melody_running, st_q.sounding, "melody without sound")

	`TMS_ASSERT_NOW(a_idle_payload,
		out_valid_q && (res_q.action != tms_pkg::ACT_START),
		(res_q.tone_freq == 16'd0) && (res_q.tone_ms == 16'd0),
		"tone fields set without a start transaction")

	`TMS_ASSERT_NEXT(a_disabled_frozen, fire_s1 && !cfg.enabled && !cfg_valid,
		$stable(st_q), "state changed while disabled")

	`TMS_ASSERT_NEXT(a_stage_moves, fire_s1, out_valid_q, "transaction lost between stages")

endmodule

@@ sim/tone_melody_sequencer_checker.sv @@
// Checker that predicts and scores every transaction of the tone melody sequencer.
`timescale 1ns / 100ps

module tone_melody_sequencer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [15:0] delay_ms,
	input  logic        driver_busy,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  action,
	input  logic [15:0] tone_freq,
	input  logic [15:0] tone_ms,
	input  logic        playing,
	input  logic        melody_on,
	input  logic        pending,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          awaiting,
	output int          results_seen,
	output int          tones_started,
	output int          stops_issued
);

	logic        cfg_on;
	logic [15:0] hz_low, hz_mid, hz_high, hz_confirm;
	logic [15:0] ms_short, ms_medium, ms_long;

	logic            buzz, tune_on, tune_err, resting, wait_armed;
	logic [1:0]      tune_pos;
	tms_pkg::timer_t note_elapsed, wait_elapsed;
	logic [15:0]     wait_target;

	tms_pkg::result_t expected_chimes[$];

	function automatic tms_pkg::timer_t bump(input tms_pkg::timer_t t);
		return (&t) ? t : t + tms_pkg::timer_t'(1);
	endfunction

	function automatic logic [1:0] tune_notes(input logic err);
		return err ? 2'd2 : 2'd3;
	endfunction

	task automatic pick_note(input logic err, input logic [1:0] pos, output logic [15:0] hz,
			output logic [15:0] ms, output logic [5:0] rest);
		if (err == tms_pkg::SEL_SUCCESS) begin
			case (pos)
				2'd0: begin
					hz = hz_low; ms = ms_short; rest = tms_pkg::PAUSE_SUCCESS;
				end
				2'd1: begin
					hz = hz_mid; ms = ms_short; rest = tms_pkg::PAUSE_SUCCESS;
				end
				default: begin
					hz = hz_high; ms = ms_medium; rest = tms_pkg::PAUSE_NONE;
				end
			endcase
		end else if (pos == 2'd0) begin
			hz = hz_mid; ms = ms_medium; rest = tms_pkg::PAUSE_ERROR;
		end else begin
			hz = hz_low; ms = ms_long; rest = tms_pkg::PAUSE_NONE;
		end
	endtask

	task automatic sound(input logic [15:0] hz, input logic [15:0] ms,
			inout tms_pkg::result_t r);
		r.action    = tms_pkg::ACT_START;
		r.tone_freq = hz;
		r.tone_ms   = ms;
	endtask

	task automatic begin_tune(input logic sel, inout tms_pkg::result_t r);
		logic [15:0] hz, ms;
		logic [5:0]  rest;
		tune_err = sel;
		tune_pos = 2'd0;
		tune_on  = 1'b1;
		resting  = 1'b0;
		pick_note(sel, 2'd0, hz, ms, rest);
		sound(hz, ms, r);
		note_elapsed = '0;
		buzz = 1'b1;
	endtask

	task automatic advance_note(inout tms_pkg::result_t r);
		logic [15:0] hz, ms;
		logic [5:0]  rest;
		tune_pos = tune_pos + 2'd1;
		resting  = 1'b0;
		if (tune_pos >= tune_notes(tune_err)) begin
			tune_on = 1'b0;
			buzz    = 1'b0;
		end else begin
			pick_note(tune_err, tune_pos, hz, ms, rest);
			sound(hz, ms, r);
			note_elapsed = '0;
		end
	endtask

	task automatic step_tune(inout tms_pkg::result_t r);
		logic [15:0] hz, ms;
		logic [5:0]  rest;
		if (tune_pos >= tune_notes(tune_err)) begin
			tune_on = 1'b0;
			buzz    = 1'b0;
		end else begin
			pick_note(tune_err, tune_pos, hz, ms, rest);
			if (resting) begin
				if (note_elapsed >= rest)
					advance_note(r);
			end else if (note_elapsed >= ms) begin
				// A note with a pause behind it silences the driver first.
				if (rest != tms_pkg::PAUSE_NONE) begin
					r.action     = tms_pkg::ACT_STOP;
					resting      = 1'b1;
					note_elapsed = '0;
				end else begin
					advance_note(r);
				end
			end
		end
	endtask

	task automatic chime_step(input logic [2:0] op, input logic [15:0] delay, input logic busy,
			output tms_pkg::result_t r);
		logic launched;
		r = '0;
		r.action = tms_pkg::ACT_NONE;
		launched = 1'b0;
		if (cfg_on) begin
			case (op)
				tms_pkg::CMD_TICK: begin
					note_elapsed = bump(note_elapsed);
					if (wait_armed)
						wait_elapsed = bump(wait_elapsed);
					if (wait_armed && wait_elapsed >= wait_target) begin
						wait_armed = 1'b0;
						begin_tune(tms_pkg::SEL_SUCCESS, r);
						launched = 1'b1;
					end
					// A melody launched by the schedule waits for the next tick to move.
					if (tune_on && !launched)
						step_tune(r);
					if (buzz && !tune_on)
						buzz = busy;
				end
				tms_pkg::CMD_DETECT: begin
					sound(hz_mid, ms_short, r);
					buzz = 1'b1;
					note_elapsed = '0;
				end
				tms_pkg::CMD_SUCCESS: begin_tune(tms_pkg::SEL_SUCCESS, r);
				tms_pkg::CMD_ERROR: begin_tune(tms_pkg::SEL_ERROR, r);
				tms_pkg::CMD_CONFIRM: begin
					sound(hz_confirm, ms_medium, r);
					buzz = 1'b1;
					note_elapsed = '0;
				end
				tms_pkg::CMD_SCHEDULE: begin
					wait_armed   = 1'b1;
					wait_elapsed = '0;
					wait_target  = delay;
				end
				tms_pkg::CMD_STOP: begin
					r.action   = tms_pkg::ACT_STOP;
					buzz       = 1'b0;
					tune_on    = 1'b0;
					wait_armed = 1'b0;
				end
				default: ;
			endcase
		end
		r.playing   = buzz;
		r.melody_on = tune_on;
		r.pending   = wait_armed;
	endtask

	task automatic apply_reg(input logic [2:0] idx, input logic [15:0] data);
		case (tms_pkg::reg_index_t'(idx))
			tms_pkg::REG_ENABLED:       cfg_on     = data[0];
			tms_pkg::REG_PITCH_LOW:     hz_low     = data;
			tms_pkg::REG_PITCH_MID:     hz_mid     = data;
			tms_pkg::REG_PITCH_HIGH:    hz_high    = data;
			tms_pkg::REG_PITCH_CONFIRM: hz_confirm = data;
			tms_pkg::REG_LEN_SHORT:     ms_short   = data;
			tms_pkg::REG_LEN_MID:       ms_medium  = data;
			tms_pkg::REG_LEN_LONG:      ms_long    = data;
			default: ;
		endcase
	endtask

	task automatic clear_model();
		cfg_on     = 1'b0;
		hz_low     = 16'd1000;
		hz_mid     = 16'd2000;
		hz_high    = 16'd3000;
		hz_confirm = 16'd2500;
		ms_short   = 16'd50;
		ms_medium  = 16'd100;
		ms_long    = 16'd200;
		buzz         = 1'b0;
		tune_on      = 1'b0;
		tune_err     = tms_pkg::SEL_SUCCESS;
		tune_pos     = 2'd0;
		resting      = 1'b0;
		note_elapsed = '0;
		wait_armed   = 1'b0;
		wait_elapsed = '0;
		wait_target  = 16'd0;
	endtask

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : score
		tms_pkg::result_t want, fresh;
		if (!arst_n) begin
			clear_model();
			expected_chimes.delete();
			errors        = 0;
			results_seen  = 0;
			tones_started = 0;
			stops_issued  = 0;
			awaiting     <= 0;
		end else begin
			// A result leaves only after its command passed both registers, so score results first.
			if (out_valid && out_ready) begin
				if (expected_chimes.size() == 0) begin
					$error("result transaction with no command waiting: action %0d", action);
					errors++;
				end else begin
					want = expected_chimes.pop_front();
					check_field("action", want.action, action);
					check_field("tone_freq", want.tone_freq, tone_freq);
					check_field("tone_ms", want.tone_ms, tone_ms);
					check_field("playing", want.playing, playing);
					check_field("melody_on", want.melody_on, melody_on);
					check_field("pending", want.pending, pending);
					results_seen++;
					if (want.action == tms_pkg::ACT_START)
						tones_started++;
					if (want.action == tms_pkg::ACT_STOP)
						stops_issued++;
				end
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				chime_step(cmd, delay_ms, driver_busy, fresh);
				expected_chimes.push_back(fresh);
			end
			awaiting <= expected_chimes.size();
		end
	end

endmodule

@@ sim/tb.sv @@
// Testbench top: clock, reset, command and register traffic, and the final verdict.
`timescale 1ns / 100ps

module tb;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 8;

	// The one command code the block leaves unused.
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	logic [2:0]  cmd         = 3'd0;
	logic [15:0] delay_ms    = 16'd0;
	logic        driver_busy = 1'b0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	logic [1:0]  action;
	logic [15:0] tone_freq;
	logic [15:0] tone_ms;
	logic        playing;
	logic        melody_on;
	logic        pending;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index   = 3'd0;
	logic [15:0] cfg_data    = 16'd0;

	int errors, awaiting, results_seen, tones_started, stops_issued;
	int items_sent     = 0;
	int reg_writes     = 0;
	int settings_used  = 0;
	bit calm           = 1'b0;
	bit hold_out       = 1'b0;

	tone_melody_sequencer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.delay_ms    (delay_ms),
		.driver_busy (driver_busy),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.action      (action),
		.tone_freq   (tone_freq),
		.tone_ms     (tone_ms),
		.playing     (playing),
		.melody_on   (melody_on),
		.pending     (pending),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tone_melody_sequencer_checker tone_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.delay_ms      (delay_ms),
		.driver_busy   (driver_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.action        (action),
		.tone_freq     (tone_freq),
		.tone_ms       (tone_ms),
		.playing       (playing),
		.melody_on     (melody_on),
		.pending       (pending),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.awaiting      (awaiting),
		.results_seen  (results_seen),
		.tones_started (tones_started),
		.stops_issued  (stops_issued)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Mostly back to back, sometimes a short pause, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [15:0] rand16(input int unsigned lo, input int unsigned hi);
		return 16'($urandom_range(hi, lo));
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(1, 0));
	endfunction

	task automatic send_item(input logic [2:0] c, input logic [15:0] d, input logic b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		delay_ms    <= d;
		driver_busy <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Lowers the command valid and waits until every result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input tms_pkg::reg_index_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic load_settings(input logic en, input logic [15:0] fl, input logic [15:0] fm,
			input logic [15:0] fh, input logic [15:0] fc, input logic [15:0] ds,
			input logic [15:0] dm, input logic [15:0] dl);
		settle();
		write_reg(tms_pkg::REG_ENABLED, {15'd0, en});
		write_reg(tms_pkg::REG_PITCH_LOW, fl);
		write_reg(tms_pkg::REG_PITCH_MID, fm);
		write_reg(tms_pkg::REG_PITCH_HIGH, fh);
		write_reg(tms_pkg::REG_PITCH_CONFIRM, fc);
		write_reg(tms_pkg::REG_LEN_SHORT, ds);
		write_reg(tms_pkg::REG_LEN_MID, dm);
		write_reg(tms_pkg::REG_LEN_LONG, dl);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly a command followed by a run of ticks long enough to carry melodies
	// through their notes and pauses; the rest is single random commands.
	task automatic random_traffic(input int count);
		int stop_at, run;
		logic [2:0]  op;
		logic [15:0] d;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 80) begin
				case ($urandom_range(0, 4))
					0: op = tms_pkg::CMD_SUCCESS;
					1: op = tms_pkg::CMD_ERROR;
					2: op = tms_pkg::CMD_SCHEDULE;
					3: op = tms_pkg::CMD_DETECT;
					default: op = tms_pkg::CMD_CONFIRM;
				endcase
				if (op == tms_pkg::CMD_SCHEDULE && $urandom_range(0, 9) != 0)
					d = rand16(0, 40);
				else
					d = rand16(0, 65535);
				send_item(op, d, rand_bit());
				run = $urandom_range(4, 110);
				// The tick run is cut short once the item budget is spent.
				while (run > 0 && items_sent < stop_at) begin
					send_item(tms_pkg::CMD_TICK, rand16(0, 65535), rand_bit());
					run--;
				end
				if (items_sent < stop_at && $urandom_range(0, 5) == 0)
					send_item(tms_pkg::CMD_STOP, rand16(0, 65535), rand_bit());
			end else begin
				send_item(3'($urandom_range(7, 0)), rand16(0, 65535), rand_bit());
			end
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request.
	initial begin : sink
		int stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the block is disabled and must ignore everything.
		send_item(tms_pkg::CMD_DETECT, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_SUCCESS, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_SCHEDULE, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b1);
		send_item(tms_pkg::CMD_STOP, 16'd0, 1'b0);
		send_item(CMD_UNUSED, 16'd0, 1'b0);

		settle();
		write_reg(tms_pkg::REG_ENABLED, 16'd1);
		cfg_valid <= 1'b0;
		settings_used++;

		send_item(tms_pkg::CMD_DETECT, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b1);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_CONFIRM, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_STOP, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_SUCCESS, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b0);
		// A lone tone in the middle of a melody restarts the note timer.
		send_item(tms_pkg::CMD_DETECT, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_ERROR, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b1);
		send_item(tms_pkg::CMD_STOP, 16'd0, 1'b0);
		send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
		// A zero delay fires on the first tick, which must not also advance the melody.
		send_item(tms_pkg::CMD_SCHEDULE, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_TICK, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_STOP, 16'd0, 1'b0);
		send_item(tms_pkg::CMD_SCHEDULE, 16'hFFFF, 1'b1);
		send_item(tms_pkg::CMD_TICK, 16'hFFFF, 1'b1);
		send_item(tms_pkg::CMD_STOP, 16'hFFFF, 1'b1);

		load_settings(1'b1, rand16(1, 65535), rand16(1, 65535),
			rand16(1, 65535), rand16(1, 65535), rand16(1, 6),
			rand16(1, 6), rand16(1, 6));
		random_traffic(120);
		// The result side holds off while commands keep coming, so the block backs up.
		hold_out = 1'b1;
		random_traffic(130);

		// Zero durations end each note on the next tick; no idling in this stretch.
		calm = 1'b1;
		load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		random_traffic(160);
		calm = 1'b0;

		load_settings(1'b1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
		random_traffic(220);

		// Disabled with a melody possibly in flight: everything freezes.
		load_settings(1'b0, rand16(0, 65535), rand16(0, 65535),
			rand16(0, 65535), rand16(0, 65535), rand16(0, 65535),
			rand16(0, 65535), rand16(0, 65535));
		random_traffic(40);

		load_settings(1'b1, rand16(1, 65535), rand16(1, 65535),
			rand16(1, 65535), rand16(1, 65535), rand16(1, 10),
			rand16(1, 10), 16'hFFFF);
		random_traffic(260);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d commands and %0d register writes across %0d settings,",
			items_sent, reg_writes, settings_used);
		$display("checking %0d results with %0d tone starts and %0d stop actions.",
			results_seen, tones_started, stops_issued);
		if (errors == 0 && awaiting == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
